### rtl/core/hdsp_pkg.sv
package hdsp_pkg;

    localparam logic [3:0] MODE_IDLE   = 4'd0;
    localparam logic [3:0] MODE_SLASH  = 4'd1;
    localparam logic [3:0] MODE_LINE   = 4'd2;
    localparam logic [3:0] MODE_BLOCK  = 4'd3;
    localparam logic [3:0] MODE_BSTAR  = 4'd4;
    localparam logic [3:0] MODE_DQ     = 4'd5;
    localparam logic [3:0] MODE_DQ_ESC = 4'd6;
    localparam logic [3:0] MODE_SQ     = 4'd7;
    localparam logic [3:0] MODE_SQ_ESC = 4'd8;
    localparam logic [3:0] MODE_FILE   = 4'd9;
    localparam logic [3:0] MODE_FLOAT  = 4'd10;
    localparam logic [3:0] MODE_HASH   = 4'd11;
    localparam logic [3:0] MODE_WS     = 4'd12;
    localparam logic [3:0] MODE_SIGN   = 4'd13;
    localparam logic [3:0] MODE_PREFIX = 4'd14;
    localparam logic [3:0] MODE_DIGITS = 4'd15;

    localparam logic [1:0] RADIX_DEC = 2'd0;
    localparam logic [1:0] RADIX_OCT = 2'd1;
    localparam logic [1:0] RADIX_HEX = 2'd2;

    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UE     = 8'h45;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_UX     = 8'h58;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LE     = 8'h65;
    localparam logic [7:0] CH_LF_    = 8'h66;
    localparam logic [7:0] CH_LN     = 8'h6E;
    localparam logic [7:0] CH_LR     = 8'h72;
    localparam logic [7:0] CH_LT_    = 8'h74;
    localparam logic [7:0] CH_LX     = 8'h78;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_word;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       mask_bit;
        logic       byte_valid;
        logic       end_of_data;
    } t_out_word;

    typedef struct packed {
        logic        en;
        logic [63:0] acc;
        logic        ovf;
        logic        neg;
        logic [1:0]  size;
    } t_num;

    typedef struct packed {
        t_num       num_a;
        logic [1:0] ext_cnt;
        logic [7:0] ext_b0;
        logic [7:0] ext_b1;
        t_num       num_b;
        logic       mask;
        logic       swap;
        logic       eod;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

### rtl/core/hdsp_front.sv
module hdsp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  hdsp_pkg::t_in_word i_word,
    output logic              o_push,
    output hdsp_pkg::t_cmd    o_cmd
);
    import hdsp_pkg::*;

    typedef struct packed {
        logic [3:0]  mode;
        logic [1:0]  size;
        logic        lnn;
        logic [3:0]  hn;
        logic        mask;
        logic        swap;
        logic [63:0] acc;
        logic        ovf;
        logic        neg;
        logic [1:0]  radix;
    } t_pst;

    typedef struct packed {
        logic       redo;
        logic       fin;
        logic [1:0] ne;
        logic [7:0] b0;
        logic [7:0] b1;
    } t_emit;

    typedef struct packed {
        t_pst  s;
        t_emit e;
    } t_step;

    localparam t_pst PST_RESET = '{mode: MODE_IDLE, size: 2'd0, lnn: 1'b0, hn: 4'd0,
                                   mask: 1'b1, swap: 1'b0, acc: 64'd0, ovf: 1'b0,
                                   neg: 1'b0, radix: RADIX_DEC};

    function automatic logic [4:0] f_digit(input logic [7:0] c);
        logic [4:0] d;
        d = 5'd16;
        if (c >= CH_ZERO && c <= CH_NINE) d = 5'(c - CH_ZERO);
        else if (c >= CH_UA && c <= CH_UF) d = 5'(c - CH_UA + 8'd10);
        else if (c >= CH_LA && c <= CH_LF_) d = 5'(c - CH_LA + 8'd10);
        return d;
    endfunction

    function automatic logic f_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [7:0] f_unesc(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c == CH_LN) r = CH_LF;
        else if (c == CH_LR) r = CH_CR;
        else if (c == CH_LT_) r = CH_TAB;
        return r;
    endfunction

    function automatic t_step f_wide(input t_step r, input logic [7:0] c);
        t_step q;
        logic [7:0] hi;
        q = r;
        hi = c[7] ? 8'hFF : 8'h00;
        q.e.ne = 2'd2;
        q.e.b0 = r.s.swap ? hi : c;
        q.e.b1 = r.s.swap ? c : hi;
        return q;
    endfunction

    function automatic t_step f_idle(input t_pst s, input logic [7:0] c);
        t_step r;
        logic [4:0] d;
        r.s = s;
        r.e = '0;
        d = f_digit(c);
        if (c == CH_QMARK) begin
            r.s.mask = ~s.mask;
        end else if (c == CH_DOLLAR) begin
            r.s.swap = ~s.swap;
        end else if (c == CH_HASH) begin
            r.s.mode  = MODE_HASH;
            r.s.size  = 2'd0;
            r.s.acc   = 64'd0;
            r.s.ovf   = 1'b0;
            r.s.neg   = 1'b0;
            r.s.radix = RADIX_DEC;
        end else if (c == CH_PCT) begin
            r.s.mode = MODE_FLOAT;
        end else if (!d[4]) begin
            if (s.lnn) begin
                r.e.ne = 2'd1;
                r.e.b0 = {s.hn, d[3:0]};
                r.s.lnn = 1'b0;
                r.s.hn  = 4'd0;
            end else begin
                r.s.hn  = d[3:0];
                r.s.lnn = 1'b1;
            end
        end else if (c == CH_DQUOTE) begin
            r.s.mode = MODE_DQ;
        end else if (c == CH_SQUOTE) begin
            r.s.mode = MODE_SQ;
        end else if (c == CH_SLASH) begin
            r.s.mode = MODE_SLASH;
        end else if (c == CH_LT) begin
            r.s.mode = MODE_FILE;
        end
        return r;
    endfunction

    function automatic t_step f_lead(input t_pst s, input logic [7:0] c, input logic open);
        t_step r;
        r.s = s;
        r.e = '0;
        if (open && f_space(c)) begin
            r.s.mode = MODE_WS;
        end else if (open && (c == CH_PLUS || c == CH_MINUS)) begin
            r.s.neg  = (c == CH_MINUS);
            r.s.mode = MODE_SIGN;
        end else if (c == CH_ZERO) begin
            r.s.acc = 64'd0;
            r.s.radix = RADIX_OCT;
            r.s.mode = MODE_PREFIX;
        end else if (c > CH_ZERO && c <= CH_NINE) begin
            r.s.acc = 64'(c - CH_ZERO);
            r.s.radix = RADIX_DEC;
            r.s.mode = MODE_DIGITS;
        end else begin
            r.e.fin  = 1'b1;
            r.e.redo = 1'b1;
            r.s.mode = MODE_IDLE;
        end
        return r;
    endfunction

    function automatic t_step f_step(input t_pst s, input logic [7:0] c);
        t_step r;
        logic [4:0] d;
        logic [4:0] base;
        logic [67:0] prod;
        logic [67:0] sum;
        r.s = s;
        r.e = '0;
        d = f_digit(c);
        base = (s.radix == RADIX_HEX) ? 5'd16 : (s.radix == RADIX_OCT) ? 5'd8 : 5'd10;
        case (s.radix)
            RADIX_HEX: prod = {s.acc, 4'd0};
            RADIX_OCT: prod = {1'b0, s.acc, 3'd0};
            default:   prod = {1'b0, s.acc, 3'd0} + {3'd0, s.acc, 1'b0};
        endcase
        sum = prod + 68'(d);
        case (s.mode)
            MODE_IDLE: r = f_idle(s, c);
            MODE_SLASH: begin
                if (c == CH_SLASH) r.s.mode = MODE_LINE;
                else if (c == CH_STAR) r.s.mode = MODE_BSTAR;
                else begin
                    r.s.mode = MODE_IDLE;
                    r.e.redo = 1'b1;
                end
            end
            MODE_LINE: if (c == CH_LF) r.s.mode = MODE_IDLE;
            MODE_BLOCK: if (c == CH_STAR) r.s.mode = MODE_BSTAR;
            MODE_BSTAR: begin
                if (c == CH_SLASH) r.s.mode = MODE_IDLE;
                else if (c != CH_STAR) r.s.mode = MODE_BLOCK;
            end
            MODE_DQ: begin
                if (c == CH_DQUOTE) r.s.mode = MODE_IDLE;
                else if (c == CH_BSLASH) r.s.mode = MODE_DQ_ESC;
                else begin
                    r.e.ne = 2'd1;
                    r.e.b0 = c;
                end
            end
            MODE_DQ_ESC: begin
                r.e.ne = 2'd1;
                r.e.b0 = f_unesc(c);
                r.s.mode = MODE_DQ;
            end
            MODE_SQ: begin
                if (c == CH_SQUOTE) r.s.mode = MODE_IDLE;
                else if (c == CH_BSLASH) r.s.mode = MODE_SQ_ESC;
                else r = f_wide(r, c);
            end
            MODE_SQ_ESC: begin
                r = f_wide(r, f_unesc(c));
                r.s.mode = MODE_SQ;
            end
            MODE_FILE: if (c == CH_GT) r.s.mode = MODE_IDLE;
            MODE_FLOAT: begin
                if (!(f_space(c) || (c >= CH_ZERO && c <= CH_NINE) || c == CH_DOT ||
                      c == CH_PLUS || c == CH_MINUS || c == CH_LE || c == CH_UE ||
                      c == CH_PCT)) begin
                    r.s.mode = MODE_IDLE;
                    r.e.redo = 1'b1;
                end
            end
            MODE_HASH: begin
                if (c == CH_HASH && s.size != 2'd3) r.s.size = s.size + 2'd1;
                else r = f_lead(s, c, 1'b1);
            end
            MODE_WS: r = f_lead(s, c, 1'b1);
            MODE_SIGN: r = f_lead(s, c, 1'b0);
            MODE_PREFIX: begin
                if (s.radix == RADIX_OCT && (c == CH_LX || c == CH_UX)) begin
                    r.s.radix = RADIX_HEX;
                end else if (d < base) begin
                    r.s.acc  = 64'(d);
                    r.s.mode = MODE_DIGITS;
                end else begin
                    r.e.fin  = 1'b1;
                    r.e.redo = 1'b1;
                    r.s.mode = MODE_IDLE;
                end
            end
            default: begin
                if (d < base) begin
                    if (!s.ovf) begin
                        if (sum[67:64] != 4'd0) r.s.ovf = 1'b1;
                        else r.s.acc = sum[63:0];
                    end
                end else begin
                    r.e.fin  = 1'b1;
                    r.e.redo = 1'b1;
                    r.s.mode = MODE_IDLE;
                end
            end
        endcase
        return r;
    endfunction

    t_pst  r_s, n_s;
    t_step w_p1, w_p2;

    always_comb begin
        w_p1 = f_step(r_s, i_word.char_code);
        w_p2 = w_p1.e.redo ? f_idle(w_p1.s, i_word.char_code) : w_p1;

        o_cmd.num_a.en   = w_p1.e.fin;
        o_cmd.num_a.acc  = r_s.acc;
        o_cmd.num_a.ovf  = r_s.ovf;
        o_cmd.num_a.neg  = r_s.neg;
        o_cmd.num_a.size = r_s.size;
        o_cmd.ext_cnt    = w_p2.e.ne;
        o_cmd.ext_b0     = w_p2.e.b0;
        o_cmd.ext_b1     = w_p2.e.b1;
        o_cmd.num_b.en   = i_word.last_char && (w_p2.s.mode >= MODE_HASH);
        o_cmd.num_b.acc  = w_p2.s.acc;
        o_cmd.num_b.ovf  = w_p2.s.ovf;
        o_cmd.num_b.neg  = w_p2.s.neg;
        o_cmd.num_b.size = w_p2.s.size;
        o_cmd.mask       = r_s.mask;
        o_cmd.swap       = r_s.swap;
        o_cmd.eod        = i_word.last_char;

        o_push = i_take && (o_cmd.num_a.en || o_cmd.ext_cnt != 2'd0 ||
                            o_cmd.num_b.en || o_cmd.eod);

        n_s = r_s;
        if (i_take) n_s = i_word.last_char ? PST_RESET : w_p2.s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s <= PST_RESET;
        else r_s <= n_s;
    end

endmodule

### rtl/core/hdsp_fifo.sv
module hdsp_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  hdsp_pkg::t_cmd       i_data,
    input  logic                 i_pop,
    output hdsp_pkg::t_cmd       o_data,
    output hdsp_pkg::t_fifo_stat o_stat
);
    import hdsp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [AW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_cnt;

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_data       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= f_inc(r_wr);
            if (i_pop) r_rd <= f_inc(r_rd);
            if (i_push && !i_pop) r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

### rtl/core/hdsp_back.sv
module hdsp_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  hdsp_pkg::t_cmd       i_cmd,
    input  logic                 i_avail,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output hdsp_pkg::t_out_word  o_word
);
    import hdsp_pkg::*;

    function automatic logic [63:0] f_value(input t_num n);
        logic [63:0] v;
        if (n.ovf) v = '1;
        else if (n.neg) v = 64'd0 - n.acc;
        else v = n.acc;
        return v;
    endfunction

    function automatic logic [3:0] f_count(input t_num n);
        return n.en ? (4'd1 << n.size) : 4'd0;
    endfunction

    logic        r_busy;
    logic [63:0] r_va, r_vb;
    logic [3:0]  r_na, r_rem_a, r_nb, r_rem_b;
    logic [1:0]  r_rem_e;
    logic [7:0]  r_e0, r_e1;
    logic        r_rem_m, r_mask, r_swap, r_eod;
    logic        r_ovalid;
    t_out_word   r_oword;

    logic        w_ready, w_emit, w_done;
    logic [2:0]  w_ka, w_kb;
    logic [3:0]  n_rem_a, n_rem_b;
    logic [1:0]  n_rem_e;
    logic        n_rem_m;
    t_out_word   w_sel;

    assign w_ready = !r_ovalid || !i_stall;
    assign w_emit  = r_busy && w_ready;
    assign w_ka = r_swap ? 3'(r_rem_a - 4'd1) : 3'(r_na - r_rem_a);
    assign w_kb = r_swap ? 3'(r_rem_b - 4'd1) : 3'(r_nb - r_rem_b);

    always_comb begin
        n_rem_a = r_rem_a;
        n_rem_b = r_rem_b;
        n_rem_e = r_rem_e;
        n_rem_m = r_rem_m;
        w_sel   = '0;
        // drain order: leading number, literal bytes, trailing number, bare marker
        if (r_rem_a != 4'd0) begin
            w_sel.byte_value = r_va[{w_ka, 3'd0} +: 8];
            w_sel.mask_bit   = r_mask;
            w_sel.byte_valid = 1'b1;
            n_rem_a = r_rem_a - 4'd1;
        end else if (r_rem_e != 2'd0) begin
            w_sel.byte_value = r_e0;
            w_sel.mask_bit   = r_mask;
            w_sel.byte_valid = 1'b1;
            n_rem_e = r_rem_e - 2'd1;
        end else if (r_rem_b != 4'd0) begin
            w_sel.byte_value = r_vb[{w_kb, 3'd0} +: 8];
            w_sel.mask_bit   = r_mask;
            w_sel.byte_valid = 1'b1;
            n_rem_b = r_rem_b - 4'd1;
        end else begin
            n_rem_m = 1'b0;
        end
        w_done = (n_rem_a == 4'd0) && (n_rem_e == 2'd0) && (n_rem_b == 4'd0) && !n_rem_m;
        w_sel.end_of_data = r_eod && w_done;
    end

    assign o_pop   = i_avail && (!r_busy || (w_emit && w_done));
    assign o_valid = r_ovalid;
    assign o_word  = r_oword;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_ready) r_ovalid <= w_emit;
            if (o_pop) r_busy <= 1'b1;
            else if (w_emit && w_done) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready) r_oword <= w_sel;
        if (o_pop) begin
            r_va    <= f_value(i_cmd.num_a);
            r_vb    <= f_value(i_cmd.num_b);
            r_na    <= f_count(i_cmd.num_a);
            r_rem_a <= f_count(i_cmd.num_a);
            r_nb    <= f_count(i_cmd.num_b);
            r_rem_b <= f_count(i_cmd.num_b);
            r_rem_e <= i_cmd.ext_cnt;
            r_e0    <= i_cmd.ext_b0;
            r_e1    <= i_cmd.ext_b1;
            r_rem_m <= i_cmd.eod && !i_cmd.num_a.en && !i_cmd.num_b.en &&
                       (i_cmd.ext_cnt == 2'd0);
            r_mask  <= i_cmd.mask;
            r_swap  <= i_cmd.swap;
            r_eod   <= i_cmd.eod;
        end else if (w_emit) begin
            r_rem_a <= n_rem_a;
            r_rem_b <= n_rem_b;
            r_rem_m <= n_rem_m;
            if (r_rem_a == 4'd0 && r_rem_e != 2'd0) begin
                r_rem_e <= n_rem_e;
                r_e0    <= r_e1;
            end
        end
    end

endmodule

### rtl/core/hex_data_string_parser.sv
// Channel   Direction  Handshake                 Word
// in        input      i_in_valid / o_in_stall   i_in_data  (char_code, last_char)
// out       output     o_out_valid / i_out_stall o_out_data (byte_value, mask_bit,
//                                                            byte_valid, end_of_data)
//
// One character is taken per cycle while the command queue has room.
// The back end drains one byte per cycle unless the output stalls; a number of 2, 4 or
// 8 bytes keeps the back end busy until all its bytes are out, so a run of wide numbers
// fills the queue and stalls input. Output is registered. Reset (synchronous, active
// low) returns the parser to idle with the mask on and empties the queue. A stall on
// the output never drops a word, it holds the back end.
module hex_data_string_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  hdsp_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output hdsp_pkg::t_out_word o_out_data
);
    import hdsp_pkg::*;

    logic       w_take, w_push, w_pop;
    t_cmd       w_cmd_in, w_cmd_out;
    t_fifo_stat w_stat;

    // accept a character whenever the queue has room for its command
    assign o_in_stall = w_stat.full;
    assign w_take     = i_in_valid && !w_stat.full;

    // front: classify the character, advance parser state, build a command
    hdsp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_word  (i_in_data),
        .o_push  (w_push),
        .o_cmd   (w_cmd_in)
    );

    // queue: decouple parsing from byte emission
    hdsp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cmd_in),
        .i_pop   (w_pop),
        .o_data  (w_cmd_out),
        .o_stat  (w_stat)
    );

    // back: expand each command into bytes, one word per cycle while the output is not stalled
    hdsp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd_out),
        .i_avail (!w_stat.empty),
        .o_pop   (w_pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_word  (o_out_data)
    );

    a_marker_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.byte_valid) |-> o_out_data.end_of_data)
        else $error("bare marker without end flag");

    a_marker_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.byte_valid) |->
        (o_out_data.byte_value == 8'd0 && !o_out_data.mask_bit))
        else $error("bare marker carries data");

    a_queue_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_stat.full && w_stat.empty))
        else $error("queue both full and empty");

    a_reset_out: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

endmodule

### dv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hdsp_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_word  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_word o_out_data;

    hex_data_string_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Free-running clock, 8 ns period.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Stop a hung run.
    initial begin
        #8ms;
        $display("Mismatches found");
        $finish;
    end

    // Parser state mirrored by the predictor.
    logic [3:0]  pmode;
    logic [1:0]  num_size;
    logic        lo_next;
    logic [3:0]  hi_nib;
    logic        mask_on;
    logic        swap_on;
    logic [63:0] num_acc;
    logic        num_ovf;
    logic        num_neg;
    logic [1:0]  num_radix;

    t_out_word   step_bytes[$];   // bytes produced by the current character
    t_out_word   pending_bytes[$]; // bytes still owed by the block
    int          mismatches = 0;
    int          chars_sent = 0;
    bit          in_idle_en = 1'b1;
    bit          out_idle_en = 1'b1;

    function automatic void clear_parser();
        pmode     = MODE_IDLE;
        num_size  = 2'd0;
        lo_next   = 1'b0;
        hi_nib    = 4'd0;
        mask_on   = 1'b1;
        swap_on   = 1'b0;
        num_acc   = 64'd0;
        num_ovf   = 1'b0;
        num_neg   = 1'b0;
        num_radix = RADIX_DEC;
    endfunction

    function automatic void put_byte(logic [7:0] b, logic m, logic v);
        t_out_word w;
        w.byte_value  = b;
        w.mask_bit    = m;
        w.byte_valid  = v;
        w.end_of_data = 1'b0;
        step_bytes = {step_bytes, w};
    endfunction

    function automatic void put_wide(logic [7:0] c);
        logic [15:0] w;
        w = {{8{c[7]}}, c};
        if (swap_on) begin
            put_byte(w[15:8], mask_on, 1'b1);
            put_byte(w[7:0], mask_on, 1'b1);
        end else begin
            put_byte(w[7:0], mask_on, 1'b1);
            put_byte(w[15:8], mask_on, 1'b1);
        end
    endfunction

    function automatic logic [4:0] digit_of(logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return 5'(c - CH_ZERO);
        if (c >= CH_UA && c <= CH_UF) return 5'(c - CH_UA + 8'd10);
        if (c >= CH_LA && c <= CH_LF_) return 5'(c - CH_LA + 8'd10);
        return 5'd16;
    endfunction

    function automatic logic [4:0] base_of();
        if (num_radix == RADIX_OCT) return 5'd8;
        if (num_radix == RADIX_HEX) return 5'd16;
        return 5'd10;
    endfunction

    function automatic logic [7:0] unescape(logic [7:0] c);
        if (c == CH_LN) return CH_LF;
        if (c == CH_LR) return CH_CR;
        if (c == CH_LT_) return CH_TAB;
        return c;
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // Emit the pending number, low byte first unless swapping.
    function automatic void flush_number();
        logic [63:0] v;
        int n;
        int k;
        if (num_ovf) v = '1;
        else if (num_neg) v = 64'd0 - num_acc;
        else v = num_acc;
        n = 1 << num_size;
        for (int i = 0; i < n; i++) begin
            k = swap_on ? (n - 1 - i) : i;
            put_byte(v[8*k +: 8], mask_on, 1'b1);
        end
        pmode = MODE_IDLE;
    endfunction

    function automatic void begin_digits(logic [63:0] d, logic [1:0] rdx, logic [3:0] m);
        num_acc   = d;
        num_radix = rdx;
        pmode     = m;
    endfunction

    // Returns 1 when the number ended and the character must be seen again.
    function automatic bit number_start(logic [7:0] c, bit open);
        if (open && is_blank(c)) begin
            pmode = MODE_WS;
        end else if (open && (c == CH_PLUS || c == CH_MINUS)) begin
            num_neg = (c == CH_MINUS);
            pmode   = MODE_SIGN;
        end else if (c == CH_ZERO) begin
            begin_digits(64'd0, RADIX_OCT, MODE_PREFIX);
        end else if (c > CH_ZERO && c <= CH_NINE) begin
            begin_digits(64'(c - CH_ZERO), RADIX_DEC, MODE_DIGITS);
        end else begin
            flush_number();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void idle_char(logic [7:0] c);
        logic [4:0] d;
        d = digit_of(c);
        if (c == CH_QMARK) begin
            mask_on = ~mask_on;
        end else if (c == CH_DOLLAR) begin
            swap_on = ~swap_on;
        end else if (c == CH_HASH) begin
            pmode     = MODE_HASH;
            num_size  = 2'd0;
            num_acc   = 64'd0;
            num_ovf   = 1'b0;
            num_neg   = 1'b0;
            num_radix = RADIX_DEC;
        end else if (c == CH_PCT) begin
            pmode = MODE_FLOAT;
        end else if (d < 16) begin
            if (lo_next) begin
                put_byte({hi_nib, d[3:0]}, mask_on, 1'b1);
                lo_next = 1'b0;
                hi_nib  = 4'd0;
            end else begin
                hi_nib  = d[3:0];
                lo_next = 1'b1;
            end
        end else if (c == CH_DQUOTE) begin
            pmode = MODE_DQ;
        end else if (c == CH_SQUOTE) begin
            pmode = MODE_SQ;
        end else if (c == CH_SLASH) begin
            pmode = MODE_SLASH;
        end else if (c == CH_LT) begin
            pmode = MODE_FILE;
        end
    endfunction

    // Advance the parser by one character; 1 means handle it again.
    function automatic bit parse_char(logic [7:0] c);
        logic [4:0]  d;
        logic [63:0] b;
        d = digit_of(c);
        case (pmode)
            MODE_IDLE: begin
                idle_char(c);
                return 1'b0;
            end
            MODE_SLASH: begin
                if (c == CH_SLASH) pmode = MODE_LINE;
                else if (c == CH_STAR) pmode = MODE_BSTAR;
                else begin
                    pmode = MODE_IDLE;
                    return 1'b1;
                end
                return 1'b0;
            end
            MODE_LINE: begin
                if (c == CH_LF) pmode = MODE_IDLE;
                return 1'b0;
            end
            MODE_BLOCK: begin
                if (c == CH_STAR) pmode = MODE_BSTAR;
                return 1'b0;
            end
            MODE_BSTAR: begin
                if (c == CH_SLASH) pmode = MODE_IDLE;
                else if (c != CH_STAR) pmode = MODE_BLOCK;
                return 1'b0;
            end
            MODE_DQ: begin
                if (c == CH_DQUOTE) pmode = MODE_IDLE;
                else if (c == CH_BSLASH) pmode = MODE_DQ_ESC;
                else put_byte(c, mask_on, 1'b1);
                return 1'b0;
            end
            MODE_DQ_ESC: begin
                put_byte(unescape(c), mask_on, 1'b1);
                pmode = MODE_DQ;
                return 1'b0;
            end
            MODE_SQ: begin
                if (c == CH_SQUOTE) pmode = MODE_IDLE;
                else if (c == CH_BSLASH) pmode = MODE_SQ_ESC;
                else put_wide(c);
                return 1'b0;
            end
            MODE_SQ_ESC: begin
                put_wide(unescape(c));
                pmode = MODE_SQ;
                return 1'b0;
            end
            MODE_FILE: begin
                if (c == CH_GT) pmode = MODE_IDLE;
                return 1'b0;
            end
            MODE_FLOAT: begin
                if (is_blank(c) || (c >= CH_ZERO && c <= CH_NINE) || c == CH_DOT ||
                    c == CH_PLUS || c == CH_MINUS || c == CH_LE || c == CH_UE ||
                    c == CH_PCT)
                    return 1'b0;
                pmode = MODE_IDLE;
                return 1'b1;
            end
            MODE_HASH: begin
                if (c == CH_HASH && num_size < 2'd3) begin
                    num_size++;
                    return 1'b0;
                end
                return number_start(c, 1'b1);
            end
            MODE_WS:   return number_start(c, 1'b1);
            MODE_SIGN: return number_start(c, 1'b0);
            MODE_PREFIX: begin
                if (num_radix == RADIX_OCT && (c == CH_LX || c == CH_UX)) begin
                    num_radix = RADIX_HEX;
                    return 1'b0;
                end
                if (d < base_of()) begin
                    begin_digits(64'(d), num_radix, MODE_DIGITS);
                    return 1'b0;
                end
                flush_number();
                return 1'b1;
            end
            default: begin
                b = 64'(base_of());
                if (d < b) begin
                    if (!num_ovf) begin
                        if (num_acc > ((64'hFFFF_FFFF_FFFF_FFFF - d) / b)) num_ovf = 1'b1;
                        else num_acc = num_acc * b + d;
                    end
                    return 1'b0;
                end
                flush_number();
                return 1'b1;
            end
        endcase
    endfunction

    // Work out the bytes one accepted character owes and queue them.
    function automatic void predict_char(logic [7:0] c, logic last);
        step_bytes.delete();
        if (parse_char(c)) void'(parse_char(c));
        if (last) begin
            if (pmode >= MODE_HASH) flush_number();
            if (step_bytes.size() == 0) put_byte(8'd0, 1'b0, 1'b0);
            step_bytes[step_bytes.size() - 1].end_of_data = 1'b1;
            clear_parser();
        end
        pending_bytes = {pending_bytes, step_bytes};
    endfunction

    // Drive one character, hold it until taken, then predict.
    // Valid stays up after the taking edge so the next character can follow at once.
    task automatic send_char(logic [7:0] c, logic last);
        @(negedge i_clk);
        while (in_idle_en && $urandom_range(0, 99) < 34) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid          = 1'b1;
        i_in_data.char_code = c;
        i_in_data.last_char = last;
        do @(posedge i_clk); while (o_in_stall);
        predict_char(c, last);
        chars_sent++;
    endtask

    task automatic send_text(byte unsigned txt[$]);
        foreach (txt[i]) send_char(txt[i], i == txt.size() - 1);
    endtask

    function automatic void add_byte(ref byte unsigned txt[$], input byte unsigned c);
        txt = {txt, c};
    endfunction

    function automatic void add_str(ref byte unsigned txt[$], input string s);
        for (int i = 0; i < s.len(); i++) add_byte(txt, s[i]);
    endfunction

    function automatic byte unsigned hex_char();
        string hexes;
        hexes = "0123456789abcdefABCDEF";
        return hexes[$urandom_range(0, 21)];
    endfunction

    // Random content for quotes; escapes now and then.
    function automatic void add_quoted(ref byte unsigned txt[$], input byte unsigned q);
        string escs;
        escs = "nrtq\\\"'x";
        add_byte(txt, q);
        repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(0, 3) == 0) begin
                add_byte(txt, CH_BSLASH);
                add_byte(txt, escs[$urandom_range(0, 7)]);
            end else begin
                add_byte(txt, 8'($urandom_range(1, 255)));
            end
        end
        add_byte(txt, q);
    endfunction

    function automatic void add_number(ref byte unsigned txt[$]);
        repeat ($urandom_range(1, 5)) add_byte(txt, CH_HASH);
        if ($urandom_range(0, 3) == 0) add_str(txt, ($urandom_range(0, 1) ? " " : "\t"));
        case ($urandom_range(0, 3))
            0: add_byte(txt, CH_MINUS);
            1: add_byte(txt, CH_PLUS);
            default: ;
        endcase
        case ($urandom_range(0, 6))
            0: repeat ($urandom_range(1, 6))
                add_byte(txt, 8'($urandom_range(CH_ZERO, CH_NINE)));
            1: begin
                add_str(txt, ($urandom_range(0, 1) ? "0x" : "0X"));
                repeat ($urandom_range(1, 16)) add_byte(txt, hex_char());
            end
            2: begin
                add_byte(txt, CH_ZERO);
                repeat ($urandom_range(0, 6))
                    add_byte(txt, 8'($urandom_range(CH_ZERO, 8'h37)));
            end
            3: add_str(txt, "0x");
            4: repeat ($urandom_range(20, 22)) add_byte(txt, CH_NINE);
            5: begin
                add_str(txt, "0x1");
                repeat (16) add_byte(txt, hex_char());
            end
            default: ;
        endcase
        if ($urandom_range(0, 1)) add_byte(txt, CH_SPACE);
    endfunction

    // Build one text from well-formed pieces with a little noise.
    function automatic void make_text(ref byte unsigned txt[$]);
        repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 15))
                0, 1: begin
                    add_byte(txt, hex_char());
                    add_byte(txt, hex_char());
                end
                2:  add_byte(txt, hex_char());
                3:  add_byte(txt, CH_QMARK);
                4:  add_byte(txt, CH_DOLLAR);
                5:  add_quoted(txt, CH_DQUOTE);
                6:  add_quoted(txt, CH_SQUOTE);
                7: begin
                    add_str(txt, "//");
                    repeat ($urandom_range(0, 3)) add_byte(txt, 8'($urandom_range(1, 255)));
                    add_byte(txt, CH_LF);
                end
                8: begin
                    if ($urandom_range(0, 2) == 0) add_str(txt, "/*/");
                    else begin
                        add_str(txt, "/*");
                        repeat ($urandom_range(0, 3))
                            add_byte(txt, 8'($urandom_range(1, 255)));
                        add_str(txt, "**/");
                    end
                end
                9, 10: add_number(txt);
                11: add_str(txt, ($urandom_range(0, 1) ? "%1.5e+3 " : "%-2E%"));
                12: add_str(txt, "<f.bin>");
                13: add_byte(txt, 8'($urandom_range(1, 255)));
                14: begin
                    add_byte(txt, CH_SLASH);
                    add_byte(txt, hex_char());
                end
                default: add_byte(txt, CH_SPACE);
            endcase
        end
    endfunction

    // Drop valid, then hold until every expected word has come out.
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_random(int n_chars);
        byte unsigned txt[$];
        int stop_at;
        stop_at = chars_sent + n_chars;
        while (chars_sent < stop_at) begin
            txt.delete();
            make_text(txt);
            send_text(txt);
        end
    endtask

    // Hex pairs, mask, swap, escapes, wide chars, comments, spans, numbers.
    task automatic test_directed();
        byte unsigned txt[$];
        add_str(txt, "0aF?f$12");
        send_text(txt);
        txt.delete();
        add_str(txt, "'\\n");
        add_byte(txt, 8'hFF);
        add_str(txt, "'$'a'");
        send_text(txt);
        txt.delete();
        add_str(txt, "\"\\r\\t\\q\"/*/7/8<9>%1e3z");
        send_text(txt);
        txt.delete();
        add_str(txt, "####-0x1F#9");
        send_text(txt);
        txt.delete();
        add_str(txt, "#+");
        send_text(txt);
        txt.delete();
        add_byte(txt, 8'h01);
        send_text(txt);
    endtask

    // Random texts with no idling on either side.
    task automatic test_back_to_back();
        in_idle_en  = 1'b0;
        out_idle_en = 1'b0;
        run_random(120);
        in_idle_en  = 1'b1;
        out_idle_en = 1'b1;
    endtask

    // Hold the input until the output side has caught up, then go on.
    task automatic test_drain_pause();
        run_random(60);
        wait_drained();
        run_random(60);
    endtask

    task automatic test_random();
        run_random(160);
    endtask

    // Random stall on the output, with a quiet stretch when idling is off.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_stall = out_idle_en && ($urandom_range(0, 99) < 34);
        end
    end

    // Compare every taken output word with the oldest expected byte.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_bytes.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %h", $time, o_out_data);
                mismatches++;
            end else begin
                if (o_out_data !== pending_bytes[0]) begin
                    $display("%0t: expected byte %h mask %b valid %b end %b, actual %h %b %b %b",
                             $time, pending_bytes[0].byte_value, pending_bytes[0].mask_bit,
                             pending_bytes[0].byte_valid, pending_bytes[0].end_of_data,
                             o_out_data.byte_value, o_out_data.mask_bit,
                             o_out_data.byte_valid, o_out_data.end_of_data);
                    mismatches++;
                end
                void'(pending_bytes.pop_front());
            end
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        clear_parser();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_back_to_back();
        test_drain_pause();
        test_random();

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending_bytes.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/hdsp_pkg.sv
rtl/core/hdsp_front.sv
rtl/core/hdsp_fifo.sv
rtl/core/hdsp_back.sv
rtl/core/hex_data_string_parser.sv
dv/testbench.sv
